>>> sv/dbm_pkg.sv
// ----------------------------------------------------------------------------
// dbm_pkg: shared types, constants and table function
// Types, register codes and the sine table generator used by the
// differential BPSK modulator and its sub-modules.
// ----------------------------------------------------------------------------
package dbm_pkg;

	localparam int unsigned PHASE_FRAC_BITS_DEF = 32;
	localparam int unsigned SINE_ADDR_BITS_DEF  = 8;
	localparam int unsigned SAMPLE_BITS_DEF     = 16;

	// Depth of the queue between the front and back parts.
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned CFG_ADDR_BITS = 4;
	localparam int unsigned CFG_DATA_BITS = 32;
	localparam int unsigned IN_DATA_BITS  = 8;
	localparam int unsigned OUT_USER_BITS = 3;

	// Output tuser bit positions.
	localparam int unsigned USER_SAMPLE_VALID = 0;
	localparam int unsigned USER_BIT_TAKEN    = 1;
	localparam int unsigned USER_DONE         = 2;

	typedef enum logic [1:0] {
		REG_PHASE_INC     = 2'd0,
		REG_BIT_CYCLES    = 2'd1,
		REG_PREAMBLE_BITS = 2'd2,
		REG_TOTAL_SAMPLES = 2'd3
	} reg_idx_t;

	typedef enum logic {
		KIND_TICK    = 1'b0,
		KIND_RESTART = 1'b1
	} item_kind_t;

	typedef struct packed {
		item_kind_t kind;
		logic       data_bit;
	} dbm_item_t;

	typedef struct packed {
		logic [31:0] phase_increment;
		logic [7:0]  bit_cycles;
		logic [15:0] preamble_bits;
		logic [31:0] total_samples;
	} dbm_cfg_t;

	// One entry of the full-wave sine table, built from a fixed-point
	// quarter-wave polynomial and mirrored by quadrant. Evaluated at
	// elaboration only.
	function automatic logic [31:0] sine_entry(input int unsigned idx,
			input int unsigned addr_bits, input int unsigned sample_bits);
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] t;
		logic [63:0] y;
		logic [63:0] s;
		logic [63:0] smax;
		int unsigned quad;
		int unsigned r;
		quad = idx >> (addr_bits - 2);
		r    = idx & ((1 << (addr_bits - 2)) - 1);
		z    = 64'(r) << (18 - addr_bits);
		if ((quad & 1) != 0) begin
			z = 64'd65536 - z;
		end
		z2   = (z * z) >> 16;
		t    = 64'd42334 - ((64'd4926 * z2) >> 16);
		t    = 64'd102944 - ((t * z2) >> 16);
		y    = (t * z) >> 16;
		smax = (64'd1 << (sample_bits - 1)) - 64'd1;
		s    = (y * smax + 64'd32768) >> 16;
		if (s > smax) begin
			s = smax;
		end
		if (quad >= 2) begin
			s = 64'd0 - s;
		end
		return s[31:0];
	endfunction

endpackage

>>> sv/dbm_front.sv
// ----------------------------------------------------------------------------
// dbm_front: input acceptance and item queue
// Takes input beats, classifies each as a sample tick or a restart and
// holds them in a short queue for the back part.
// ----------------------------------------------------------------------------
module dbm_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [dbm_pkg::IN_DATA_BITS-1:0] s_axis_tdata,  // [0] data_bit
	input  logic                             s_axis_tuser,  // [0] operation
	output logic                             item_valid,
	output dbm_pkg::dbm_item_t               item,
	input  logic                             item_pop
);
	import dbm_pkg::*;

	localparam int unsigned QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	dbm_item_t             queue_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q;
	logic [QPTR_BITS-1:0]  rd_ptr_q;
	logic [QCNT_BITS-1:0]  count_q;
	dbm_item_t             in_item;
	logic                  push;
	logic                  pop;

	assign in_item.kind     = s_axis_tuser ? KIND_RESTART : KIND_TICK;
	assign in_item.data_bit = s_axis_tdata[0];

	assign s_axis_tready = (count_q != QCNT_BITS'(QUEUE_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign item_valid    = (count_q != '0);
	assign pop           = item_pop && item_valid;
	assign item          = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/dbm_back.sv
// ----------------------------------------------------------------------------
// dbm_back: carrier oscillator, bit sequencing and result register
// Carries out queued items: phase accumulation, bit-boundary handling,
// differential inversion, sine lookup and the registered result beat.
// ----------------------------------------------------------------------------
module dbm_back #(
	parameter int unsigned PHASE_FRAC_BITS = dbm_pkg::PHASE_FRAC_BITS_DEF,
	parameter int unsigned SINE_ADDR_BITS  = dbm_pkg::SINE_ADDR_BITS_DEF,
	parameter int unsigned SAMPLE_BITS     = dbm_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned OUT_DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dbm_pkg::dbm_cfg_t                 cfg,
	input  logic                              item_valid,
	input  dbm_pkg::dbm_item_t                item,
	output logic                              item_pop,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [OUT_DATA_BITS-1:0]          m_axis_tdata,  // [SAMPLE_BITS-1:0] sample
	output logic [dbm_pkg::OUT_USER_BITS-1:0] m_axis_tuser   // [0] valid [1] taken [2] done
);
	import dbm_pkg::*;

	localparam int unsigned PW         = PHASE_FRAC_BITS + 8;
	localparam int unsigned TABLE_SIZE = 1 << SINE_ADDR_BITS;

	logic signed [SAMPLE_BITS-1:0] rom [TABLE_SIZE];

	for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
		localparam logic [31:0] ENTRY = sine_entry(g, SINE_ADDR_BITS, SAMPLE_BITS);
		assign rom[g] = ENTRY[SAMPLE_BITS-1:0];
	end

	logic [PW-1:0]  phase_q;
	logic           invert_q;
	logic           first_q;
	logic           prev_bit_q;
	logic [15:0]    train_q;
	logic [31:0]    count_q;

	logic [PW-1:0]  phase_n;
	logic           invert_n;
	logic           first_n;
	logic           prev_bit_n;
	logic [15:0]    train_n;
	logic [31:0]    count_n;

	logic [PW-1:0]  period;
	logic [PW:0]    diff;
	logic           boundary;
	logic [PW-1:0]  phase_cur;
	logic [SINE_ADDR_BITS-1:0] idx;
	logic signed [SAMPLE_BITS-1:0] table_val;
	logic signed [SAMPLE_BITS-1:0] sample_n;
	logic           valid_n;
	logic           taken_n;
	logic           done_n;

	// The back part advances whenever an item is queued and the result register is free or drained.
	assign item_pop = item_valid && (!m_axis_tvalid || m_axis_tready);

	assign period    = {cfg.bit_cycles, {PHASE_FRAC_BITS{1'b0}}};
	assign diff      = {1'b0, phase_q} - {1'b0, period};
	assign boundary  = !diff[PW];
	assign phase_cur = boundary ? diff[PW-1:0] : phase_q;
	assign idx       = phase_cur[PHASE_FRAC_BITS-1 -: SINE_ADDR_BITS];
	assign table_val = rom[idx];

	always_comb begin
		phase_n    = phase_q;
		invert_n   = invert_q;
		first_n    = first_q;
		prev_bit_n = prev_bit_q;
		train_n    = train_q;
		count_n    = count_q;
		sample_n   = '0;
		valid_n    = 1'b0;
		taken_n    = 1'b0;
		if (item.kind == KIND_RESTART) begin
			phase_n    = period;
			invert_n   = 1'b0;
			first_n    = 1'b1;
			prev_bit_n = 1'b0;
			train_n    = '0;
			count_n    = '0;
		end else begin
			phase_n = phase_cur;
			if (boundary) begin
				if (train_q >= cfg.preamble_bits) begin
					taken_n = 1'b1;
					// The first data bit always flips the carrier.
					if (first_q || (item.data_bit != prev_bit_q)) begin
						invert_n   = !invert_q;
						prev_bit_n = item.data_bit;
						first_n    = 1'b0;
					end
				end else begin
					train_n = train_q + 16'd1;
				end
			end
			if (count_q < cfg.total_samples) begin
				sample_n = invert_n ? -table_val : table_val;
				valid_n  = 1'b1;
				phase_n  = phase_cur + PW'(cfg.phase_increment);
				count_n  = count_q + 32'd1;
			end
		end
		done_n = (count_n >= cfg.total_samples);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PW'(1) << PHASE_FRAC_BITS;
			invert_q      <= 1'b0;
			first_q       <= 1'b1;
			prev_bit_q    <= 1'b0;
			train_q       <= '0;
			count_q       <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (item_pop) begin
				phase_q    <= phase_n;
				invert_q   <= invert_n;
				first_q    <= first_n;
				prev_bit_q <= prev_bit_n;
				train_q    <= train_n;
				count_q    <= count_n;
			end
			if (item_pop) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			m_axis_tdata                    <= OUT_DATA_BITS'($unsigned(sample_n));
			m_axis_tuser[USER_SAMPLE_VALID] <= valid_n;
			m_axis_tuser[USER_BIT_TAKEN]    <= taken_n;
			m_axis_tuser[USER_DONE]         <= done_n;
		end
	end

endmodule

>>> sv/differential_bpsk_modulator.sv
// ----------------------------------------------------------------------------
// differential_bpsk_modulator: NCO-based differential BPSK modulator
// Top level with the configuration registers, the input front part and
// the modulating back part.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock, sustained while the output is
// not stalled, and gives one result beat for each. A beat is held in a
// two-entry queue, taken from it by the back part and shown as a registered
// result. The rate is set by the back part's phase loop: compare with the
// bit period, subtract, table lookup and increment are all combinational.
// The sine table is constant logic, so there is no start-up pass after reset.
// The user must write registers through the APB port only while no beat is
// in flight; the block itself does not enforce this.
module differential_bpsk_modulator #(
	parameter int unsigned PHASE_FRAC_BITS = dbm_pkg::PHASE_FRAC_BITS_DEF,
	parameter int unsigned SINE_ADDR_BITS  = dbm_pkg::SINE_ADDR_BITS_DEF,
	parameter int unsigned SAMPLE_BITS     = dbm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [dbm_pkg::CFG_ADDR_BITS-1:0]       paddr,
	input  logic [dbm_pkg::CFG_DATA_BITS-1:0]       pwdata,
	output logic [dbm_pkg::CFG_DATA_BITS-1:0]       prdata,
	output logic                                    pready,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [dbm_pkg::IN_DATA_BITS-1:0]        s_axis_tdata,  // [0] data_bit
	input  logic                                    s_axis_tuser,  // [0] operation
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,  // sample
	output logic [dbm_pkg::OUT_USER_BITS-1:0]       m_axis_tuser   // valid, taken, done
);
	import dbm_pkg::*;

	localparam int unsigned OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

	dbm_cfg_t  cfg_q;
	reg_idx_t  reg_idx;
	logic      wr_en;
	logic      item_valid;
	dbm_item_t item;
	logic      item_pop;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_increment <= '0;
			cfg_q.bit_cycles      <= 8'd1;
			cfg_q.preamble_bits   <= '0;
			cfg_q.total_samples   <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PHASE_INC:     cfg_q.phase_increment <= pwdata;
				REG_BIT_CYCLES:    cfg_q.bit_cycles      <= pwdata[7:0];
				REG_PREAMBLE_BITS: cfg_q.preamble_bits   <= pwdata[15:0];
				REG_TOTAL_SAMPLES: cfg_q.total_samples   <= pwdata;
				default:           cfg_q                 <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PHASE_INC:     prdata = cfg_q.phase_increment;
			REG_BIT_CYCLES:    prdata = CFG_DATA_BITS'(cfg_q.bit_cycles);
			REG_PREAMBLE_BITS: prdata = CFG_DATA_BITS'(cfg_q.preamble_bits);
			REG_TOTAL_SAMPLES: prdata = cfg_q.total_samples;
			default:           prdata = '0;
		endcase
	end

	dbm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.item_valid    (item_valid),
		.item          (item),
		.item_pop      (item_pop)
	);

	dbm_back #(
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS),
		.SINE_ADDR_BITS  (SINE_ADDR_BITS),
		.SAMPLE_BITS     (SAMPLE_BITS),
		.OUT_DATA_BITS   (OUT_DATA_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.item_valid    (item_valid),
		.item          (item),
		.item_pop      (item_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

>>> sv/dbm_checker.sv
// ----------------------------------------------------------------------------
// dbm_checker: port-level checks for the modulator
// Watches the top-level ports of the modulator and is bound to it.
// ----------------------------------------------------------------------------
module dbm_checker #(
	parameter int unsigned OUT_DATA_BITS = 16
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                psel,
	input logic                                penable,
	input logic                                pwrite,
	input logic [dbm_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input logic [dbm_pkg::CFG_DATA_BITS-1:0]   pwdata,
	input logic [dbm_pkg::CFG_DATA_BITS-1:0]   prdata,
	input logic                                pready,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [OUT_DATA_BITS-1:0]            m_axis_tdata,
	input logic [dbm_pkg::OUT_USER_BITS-1:0]   m_axis_tuser
);
	import dbm_pkg::*;

	logic wr_done;

	assign wr_done = psel && penable && pwrite && pready;

	// A stalled result beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("result beat changed while stalled");

	// A beat without a sample carries an all-zero sample.
	a_idle_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[USER_SAMPLE_VALID]) |-> (m_axis_tdata == '0))
		else $error("sample present on a beat without a sample");

	// The increment register reads back what was last written to it.
	a_inc_readback: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && $past(wr_done) && ($past(paddr[3:2]) == REG_PHASE_INC)
			&& (paddr[3:2] == REG_PHASE_INC)) |-> (prdata == $past(pwdata)))
		else $error("phase increment read-back mismatch");

	// The sample-count register reads back what was last written to it.
	a_total_readback: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && $past(wr_done) && ($past(paddr[3:2]) == REG_TOTAL_SAMPLES)
			&& (paddr[3:2] == REG_TOTAL_SAMPLES)) |-> (prdata == $past(pwdata)))
		else $error("total samples read-back mismatch");

endmodule

bind differential_bpsk_modulator dbm_checker #(
	.OUT_DATA_BITS (OUT_DATA_BITS)
) u_dbm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.paddr         (paddr),
	.pwdata        (pwdata),
	.prdata        (prdata),
	.pready        (pready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for differential_bpsk_modulator
// Drives tick and restart beats into the stream input and programs the four
// registers over APB between phases. A table of directed beats comes first,
// then random phases with random settings. Every input beat is run through
// a local model of the phase loop, sine lookup and differential inversion,
// and each output beat is checked field by field against the oldest
// expectation. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
	import dbm_pkg::*;

	localparam int unsigned RANDOM_BEATS = 1650;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned IDLE_PCT     = 24;

	typedef struct packed {
		logic [15:0] sample;
		logic        valid;
		logic        taken;
		logic        done;
	} beat_t;

	typedef struct packed {
		logic       is_write;
		reg_idx_t   idx;
		logic [31:0] value;
		item_kind_t kind;
		logic       dbit;
		logic       literal;
		beat_t      want;
	} step_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [CFG_ADDR_BITS-1:0] paddr = '0;
	logic [CFG_DATA_BITS-1:0] pwdata = '0;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;   // [0] data_bit
	logic        s_axis_tuser = 1'b0;              // [0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;                     // [15:0] sample
	logic [OUT_USER_BITS-1:0] m_axis_tuser;        // [0] valid, [1] taken, [2] done

	differential_bpsk_modulator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Register copies and modulator state as the bench sees them.
	logic [31:0] inc_cfg;
	logic [7:0]  cpb_cfg;
	logic [15:0] train_cfg;
	logic [31:0] total_cfg;
	logic [39:0] phase_q;
	logic        inverted;
	logic        awaiting_first;
	logic        prev_dbit;
	logic [15:0] train_sent;
	logic [31:0] emitted;
	logic signed [15:0] sine_lut [256];

	beat_t       expected_beats [$];
	int unsigned errors = 0;
	int unsigned beats_seen = 0;
	int unsigned cycle_count = 0;
	bit          calm = 1'b0;

	function automatic void rearm();
		phase_q        = {cpb_cfg, 32'd0};
		inverted       = 1'b0;
		awaiting_first = 1'b1;
		prev_dbit      = 1'b0;
		train_sent     = '0;
		emitted        = '0;
	endfunction

	// One beat of the modulator: a restart rearms the state; a tick handles the bit boundary, then the sample.
	function automatic beat_t modulate(item_kind_t kind, logic dbit);
		beat_t r;
		logic [39:0] period;
		logic signed [15:0] v;
		r = '0;
		period = {cpb_cfg, 32'd0};
		if (kind == KIND_RESTART) begin
			rearm();
		end else begin
			if (phase_q >= period) begin
				phase_q = phase_q - period;
				if (train_sent >= train_cfg) begin
					r.taken = 1'b1;
					if (awaiting_first || dbit != prev_dbit) begin
						inverted       = !inverted;
						prev_dbit      = dbit;
						awaiting_first = 1'b0;
					end
				end else begin
					train_sent = train_sent + 16'd1;
				end
			end
			if (emitted < total_cfg) begin
				v = sine_lut[phase_q[31:24]];
				r.sample = inverted ? 16'(-v) : v;
				r.valid = 1'b1;
				phase_q = phase_q + {8'd0, inc_cfg};
				emitted = emitted + 32'd1;
			end
		end
		r.done = (emitted >= total_cfg);
		return r;
	endfunction

	function automatic step_row_t wr_row(reg_idx_t idx, logic [31:0] value);
		step_row_t r;
		r = '0;
		r.is_write = 1'b1;
		r.idx = idx;
		r.value = value;
		return r;
	endfunction

	function automatic step_row_t tick_row(item_kind_t kind, logic dbit);
		step_row_t r;
		r = '0;
		r.kind = kind;
		r.dbit = dbit;
		return r;
	endfunction

	function automatic step_row_t lit_row(item_kind_t kind, logic dbit, beat_t want);
		step_row_t r;
		r = tick_row(kind, dbit);
		r.literal = 1'b1;
		r.want = want;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
		errors++;
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PHASE_INC:     inc_cfg   = value;
			REG_BIT_CYCLES:    cpb_cfg   = value[7:0];
			REG_PREAMBLE_BITS: train_cfg = value[15:0];
			REG_TOTAL_SAMPLES: total_cfg = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Stop sending and wait for every outstanding result beat.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0) @(posedge clk);
	endtask

	task automatic send_item(input item_kind_t kind, input logic dbit,
			input logic literal, input beat_t lit);
		beat_t want;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_BITS-1){1'b0}}, dbit};
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		want = modulate(kind, dbit);
		expected_beats.push_back(literal ? lit : want);
	endtask

	task automatic check_beat();
		beat_t want;
		beats_seen++;
		if (expected_beats.size() == 0) begin
			report_mismatch($sformatf("result beat %0d with nothing expected", beats_seen));
		end else begin
			want = expected_beats.pop_front();
			if (m_axis_tdata !== want.sample)
				report_mismatch($sformatf("beat %0d sample %0h, expected %0h",
					beats_seen, m_axis_tdata, want.sample));
			if (m_axis_tuser[USER_SAMPLE_VALID] !== want.valid)
				report_mismatch($sformatf("beat %0d sample_valid %b, expected %b",
					beats_seen, m_axis_tuser[USER_SAMPLE_VALID], want.valid));
			if (m_axis_tuser[USER_BIT_TAKEN] !== want.taken)
				report_mismatch($sformatf("beat %0d bit_taken %b, expected %b",
					beats_seen, m_axis_tuser[USER_BIT_TAKEN], want.taken));
			if (m_axis_tuser[USER_DONE] !== want.done)
				report_mismatch($sformatf("beat %0d done %b, expected %b",
					beats_seen, m_axis_tuser[USER_DONE], want.done));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) check_beat();
	end

	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		step_row_t   directed [$];
		longint unsigned z, z2, t, y, s;
		int unsigned sent, phase_len, n, pick;
		item_kind_t  kind;

		// Full-wave table from the quarter-wave polynomial, mirrored by quadrant.
		for (int i = 0; i < 256; i++) begin
			z = longint'(i % 64) << 10;
			if (((i / 64) % 2) == 1) z = 65536 - z;
			z2 = (z * z) >> 16;
			t  = 42334 - ((4926 * z2) >> 16);
			t  = 102944 - ((t * z2) >> 16);
			y  = (t * z) >> 16;
			s  = (y * 32767 + 32768) >> 16;
			if (s > 32767) s = 32767;
			sine_lut[i] = (i >= 128) ? -16'(s) : 16'(s);
		end

		inc_cfg   = '0;
		cpb_cfg   = 8'd1;
		train_cfg = '0;
		total_cfg = '0;
		rearm();

		directed = '{
			// Straight after reset the first tick sits on a bit boundary.
			lit_row(KIND_TICK, 1'b0, '{16'd0, 1'b0, 1'b1, 1'b1}),
			lit_row(KIND_TICK, 1'b1, '{16'd0, 1'b0, 1'b0, 1'b1}),
			lit_row(KIND_RESTART, 1'b1, '{16'd0, 1'b0, 1'b0, 1'b1}),
			wr_row(REG_PHASE_INC, 32'h8000_0000),
			wr_row(REG_BIT_CYCLES, 32'd1),
			wr_row(REG_PREAMBLE_BITS, 32'd2),
			wr_row(REG_TOTAL_SAMPLES, 32'd12),
			lit_row(KIND_RESTART, 1'b0, '{16'd0, 1'b0, 1'b0, 1'b0}),
			// Two training bits, then data; runs past done to see a bit
			// taken without a sample.
			tick_row(KIND_TICK, 1'b0), tick_row(KIND_TICK, 1'b1),
			tick_row(KIND_TICK, 1'b1), tick_row(KIND_TICK, 1'b0),
			tick_row(KIND_TICK, 1'b1), tick_row(KIND_TICK, 1'b0),
			tick_row(KIND_TICK, 1'b0), tick_row(KIND_TICK, 1'b1),
			tick_row(KIND_TICK, 1'b1), tick_row(KIND_TICK, 1'b1),
			tick_row(KIND_TICK, 1'b0), tick_row(KIND_TICK, 1'b0),
			tick_row(KIND_TICK, 1'b1), tick_row(KIND_TICK, 1'b0),
			// A zero bit period makes every tick a boundary.
			wr_row(REG_BIT_CYCLES, 32'd0),
			tick_row(KIND_TICK, 1'b1),
			tick_row(KIND_RESTART, 1'b0),
			tick_row(KIND_TICK, 1'b1), tick_row(KIND_TICK, 1'b0),
			wr_row(REG_PREAMBLE_BITS, 32'd65535),
			wr_row(REG_BIT_CYCLES, 32'd255),
			wr_row(REG_PHASE_INC, 32'd1),
			wr_row(REG_TOTAL_SAMPLES, 32'hFFFF_FFFF),
			tick_row(KIND_RESTART, 1'b1),
			tick_row(KIND_TICK, 1'b1), tick_row(KIND_TICK, 1'b0)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_write) begin
				settle();
				apb_write(directed[i].idx, directed[i].value);
			end else begin
				send_item(directed[i].kind, directed[i].dbit, directed[i].literal,
					directed[i].want);
			end
		end

		sent = 0;
		while (sent < RANDOM_BEATS) begin
			settle();
			if ($urandom_range(99) < 60) begin
				pick = $urandom_range(99);
				apb_write(REG_PHASE_INC,
					(pick < 50) ? $urandom_range(32'h8000_0000, 32'h1000_0000) :
					(pick < 80) ? $urandom_range(32'h8000_0000, 0) :
					(pick < 90) ? 32'h8000_0000 : 32'd0);
			end
			if ($urandom_range(99) < 60) begin
				pick = $urandom_range(99);
				apb_write(REG_BIT_CYCLES,
					(pick < 70) ? $urandom_range(3) :
					(pick < 90) ? $urandom_range(16, 4) : $urandom_range(255, 17));
			end
			if ($urandom_range(99) < 60) begin
				pick = $urandom_range(99);
				apb_write(REG_PREAMBLE_BITS,
					(pick < 60) ? $urandom_range(3) :
					(pick < 90) ? $urandom_range(20, 4) :
					(pick < 95) ? 32'd65535 : $urandom);
			end
			if ($urandom_range(99) < 60) begin
				pick = $urandom_range(99);
				apb_write(REG_TOTAL_SAMPLES,
					(pick < 60) ? $urandom_range(300, 20) :
					(pick < 80) ? $urandom_range(10) :
					(pick < 90) ? 32'hFFFF_FFFF : $urandom);
			end
			// Without a restart here the new settings act on a run in progress.
			if ($urandom_range(99) < 70) begin
				send_item(KIND_RESTART, $urandom_range(1), 1'b0, '0);
				sent++;
			end
			phase_len = $urandom_range(200, 40);
			for (n = 0; n < phase_len && sent < RANDOM_BEATS; n++) begin
				calm = (sent >= 700 && sent < 950);
				if (sent == 400) settle();
				kind = ($urandom_range(99) < 3) ? KIND_RESTART : KIND_TICK;
				send_item(kind, $urandom_range(1), 1'b0, '0);
				sent++;
			end
		end
		calm = 1'b0;

		settle();
		repeat (8) @(posedge clk);
		if (expected_beats.size() != 0)
			report_mismatch($sformatf("%0d result beats never arrived",
				expected_beats.size()));

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/dbm_pkg.sv
sv/dbm_front.sv
sv/dbm_back.sv
sv/differential_bpsk_modulator.sv
sv/dbm_checker.sv
tb/tb.sv
